// ===== src/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

  // command codes
  localparam logic [2:0] CMD_REDUCE = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_SUB    = 3'd2;
  localparam logic [2:0] CMD_MUL    = 3'd3;
  localparam logic [2:0] CMD_DIV    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_COMB  = 9'b000001000,
    S_GCD   = 9'b000010000,
    S_DIVN  = 9'b000100000,
    S_DIVD  = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // shared unit control
  typedef struct packed {
    logic start;
    logic mode_div;
  } ctl_t;

endpackage
`default_nettype wire

// ===== src/rau_iter.sv =====
`default_nettype none
// Shared iterative unit: binary gcd or restoring 64-bit division, one step a cycle.
// Division takes 64 steps, then flags the quotient in a with done_o.
module rau_iter (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rau_pkg::ctl_t ctl_i,
  input  wire logic [63:0]  x_i,
  input  wire logic [63:0]  y_i,
  output logic              done_o,
  output logic [63:0]       res_o
);
  import rau_pkg::*;

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic [63:0] r_q, r_d;
  logic [6:0]  k_q, k_d;
  logic [64:0] trial;

  assign trial = {r_q, a_q[63]} - {1'b0, b_q};

  // one step of the selected algorithm; a new start overrides the step
  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    a_d = a_q;
    b_d = b_q;
    r_d = r_q;
    k_d = k_q;
    done_o = 1'b0;
    if (busy_q) begin
      if (div_q) begin
        if (k_q == 7'd64) begin
          // quotient complete in a
          busy_d = 1'b0;
          done_o = 1'b1;
        end else begin
          // restoring division: a holds quotient bits shifting in
          if (trial[64]) begin
            r_d = {r_q[62:0], a_q[63]};
            a_d = {a_q[62:0], 1'b0};
          end else begin
            r_d = trial[63:0];
            a_d = {a_q[62:0], 1'b1};
          end
          k_d = k_q + 7'd1;
        end
      end else begin
        // binary gcd, k counts common factors of two
        if (a_q == b_q || b_q == '0) begin
          busy_d = 1'b0;
          done_o = 1'b1;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 7'd1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q > b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
    end
    if (ctl_i.start) begin
      busy_d = 1'b1;
      div_d  = ctl_i.mode_div;
      a_d = x_i;
      b_d = y_i;
      r_d = '0;
      k_d = '0;
    end
  end

  assign res_o = div_q ? a_q : (a_q << k_q[5:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end
endmodule
`default_nettype wire

// ===== src/rational_arith_unit.sv =====
`default_nettype none
// Rational arithmetic unit: reduce, add, subtract, multiply or divide two
// signed fractions, result in lowest terms with a positive denominator.
// Command channel: an item is taken when start_i is high and busy_o is low.
// busy_o rises the next cycle and stays high through the result cycle.
// Result channel: done_o pulses for one cycle with res_num_o, res_den_o and
// status_o; the receiver cannot stall and must take it then.
// Steps from the accepting edge to the result: error items go from MUL1 to
// DONE, zero numerators from COMB to DONE. Others form the fraction in MUL1,
// MUL2 (not for reduce) and COMB, run binary gcd and two divisions by the
// gcd in the shared unit, then pass CHECK and DONE.
// The shared gcd/divide unit sets the rate; one item is in flight at a time.
// Only the low OPERAND_WIDTH bits of each operand are used, sign-extended.
// Reset returns the sequencer to idle; no result is pending after reset.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic             done_o,
  output logic [63:0]      res_num_o,
  output logic [62:0]      res_den_o,
  output logic [1:0]       status_o
);
  import rau_pkg::*;

  state_e      st_q, st_d;
  logic [2:0]  cmd_q;
  logic        an_s, ad_s, bn_s, bd_s;
  logic [31:0] an_m, ad_m, bn_m, bd_m;
  logic        an_sq, ad_sq, bn_sq, bd_sq;
  logic [31:0] an_q, ad_q, bn_q, bd_q;
  logic [63:0] p_q, q_q, nm_q, dm_q, g_q;
  logic        pn_q, qn_q, nn_q, dn_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_r;
  logic        mul_neg;
  logic [1:0]  stat_q;
  logic [63:0] onum_q;
  logic [62:0] oden_q;
  logic        done_q;
  ctl_t        ctl;
  logic [63:0] ux, uy, ures;
  logic        udone;
  logic [2:0]  cmd_in;
  logic [63:0] sum;
  logic [63:0] cn_m, cd_m;
  logic        cn_s, cd_s;

  // operand sign and magnitude from the low OPERAND_WIDTH bits
  function automatic logic [32:0] take(input logic [31:0] raw);
    logic [31:0] v;
    v = 32'($signed(raw[OPERAND_WIDTH-1:0]));
    take = {v[31], v[31] ? (32'd0 - v) : v};
  endfunction

  assign {an_s, an_m} = take(a_num_i);
  assign {ad_s, ad_m} = take(a_den_i);
  assign {bn_s, bn_m} = take(b_num_i);
  assign {bd_s, bd_m} = take(b_den_i);
  assign cmd_in = (command_i > CMD_DIV) ? CMD_REDUCE : command_i;

  // one shared 32x32 multiplier: MUL1 and MUL2 form an*bn and ad*bd for multiply,
  // cross products otherwise; ad*bd in COMB (add/subtract denominator)
  always_comb begin
    mul_a   = ad_q;
    mul_b   = bd_q;
    mul_neg = ad_sq ^ bd_sq;
    if (st_q == S_MUL1) begin
      mul_a   = an_q;
      mul_b   = (cmd_q == CMD_MUL) ? bn_q : bd_q;
      mul_neg = an_sq ^ ((cmd_q == CMD_MUL) ? bn_sq : bd_sq);
    end else if (st_q == S_MUL2 && cmd_q == CMD_DIV) begin
      mul_a   = ad_q;
      mul_b   = bn_q;
      mul_neg = ad_sq ^ bn_sq;
    end else if (st_q == S_MUL2 && cmd_q != CMD_MUL) begin
      mul_a   = bn_q;
      mul_b   = ad_q;
      mul_neg = bn_sq ^ ad_sq ^ (cmd_q == CMD_SUB);
    end
  end
  assign mul_r = {32'd0, mul_a} * {32'd0, mul_b};

  // signed-magnitude sum of the cross products, at most 2^63
  always_comb begin
    if (pn_q == qn_q) sum = p_q + q_q;
    else if (p_q >= q_q) sum = p_q - q_q;
    else sum = q_q - p_q;
  end

  // unreduced fraction as formed in COMB
  always_comb begin
    case (cmd_q)
      CMD_ADD, CMD_SUB: begin
        cn_m = sum;
        cn_s = (p_q >= q_q || pn_q == qn_q) ? pn_q : qn_q;
        cd_m = mul_r;
        cd_s = mul_neg;
      end
      CMD_MUL, CMD_DIV: begin
        cn_m = p_q;
        cn_s = pn_q;
        cd_m = q_q;
        cd_s = qn_q;
      end
      default: begin
        cn_m = {32'd0, an_q};
        cn_s = an_sq;
        cd_m = {32'd0, ad_q};
        cd_s = ad_sq;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    ux  = nm_q;
    uy  = dm_q;
    if (st_q == S_COMB && cn_m != '0) begin
      ctl.start = 1'b1;
      ux = cn_m;
      uy = cd_m;
    end
    if (st_q == S_GCD && udone) begin
      ctl.start = 1'b1;
      ctl.mode_div = 1'b1;
      ux = nm_q;
      uy = ures;
    end
    if (st_q == S_DIVN && udone) begin
      ctl.start = 1'b1;
      ctl.mode_div = 1'b1;
      ux = dm_q;
      uy = g_q;
    end
  end

  rau_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .x_i    (ux),
    .y_i    (uy),
    .done_o (udone),
    .res_o  (ures)
  );

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (start_i && !busy_o) st_d = S_MUL1;
      S_MUL1:  st_d = (stat_q != ST_OK) ? S_DONE :
                      (cmd_q == CMD_REDUCE) ? S_COMB : S_MUL2;
      S_MUL2:  st_d = S_COMB;
      S_COMB:  st_d = ctl.start ? S_GCD : S_DONE;
      S_GCD:   if (udone) st_d = S_DIVN;
      S_DIVN:  if (udone) st_d = S_DIVD;
      S_DIVD:  if (udone) st_d = S_CHECK;
      S_CHECK: st_d = S_DONE;
      S_DONE:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == S_DONE);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cmd_q <= cmd_in;
        {an_sq, an_q} <= {an_s, an_m};
        {ad_sq, ad_q} <= {ad_s, ad_m};
        {bn_sq, bn_q} <= {bn_s, bn_m};
        {bd_sq, bd_q} <= {bd_s, bd_m};
        if (ad_m == '0 || (cmd_in != CMD_REDUCE && bd_m == '0)) stat_q <= ST_ZERO_DEN;
        else if (cmd_in == CMD_DIV && bn_m == '0) stat_q <= ST_DIV_ZERO;
        else stat_q <= ST_OK;
        onum_q <= '0;
        oden_q <= '0;
      end
      S_MUL1: begin
        p_q  <= mul_r;
        pn_q <= mul_neg;
      end
      S_MUL2: begin
        q_q  <= mul_r;
        qn_q <= mul_neg;
      end
      S_COMB: begin
        nm_q <= cn_m; nn_q <= cn_s;
        dm_q <= cd_m; dn_q <= cd_s;
        if (!ctl.start) begin
          onum_q <= '0;
          oden_q <= 63'd1;
        end
      end
      S_GCD: if (udone) g_q <= ures;
      S_DIVN: if (udone) nm_q <= ures;
      S_DIVD: if (udone) dm_q <= ures;
      S_CHECK: begin
        if (nm_q == '0) begin
          onum_q <= '0;
          oden_q <= 63'd1;
        end else if (dm_q[63] || nm_q > 64'h8000_0000_0000_0000 ||
            (!(nn_q ^ dn_q) && nm_q[63])) begin
          stat_q <= ST_OVERFLOW;
        end else begin
          onum_q <= (nn_q ^ dn_q) ? (64'd0 - nm_q) : nm_q;
          oden_q <= dm_q[62:0];
        end
      end
      default: ;
    endcase
  end

  assign busy_o    = (st_q != S_IDLE) || done_q;
  assign done_o    = done_q;
  assign res_num_o = onum_q;
  assign res_den_o = oden_q;
  assign status_o  = stat_q;
endmodule
`default_nettype wire

// ===== src/rau_checker.sv =====
`default_nettype none
// Port-level checks on the command and result channels.
module rau_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [62:0] res_den_o,
  input wire logic [1:0]  status_o
);
  import rau_pkg::*;

  // an accepted item makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after accept");

  // strobe lasts one cycle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");

  // result only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result while idle");

  // ok results have a positive denominator, errors a zero one
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == ST_OK) == (res_den_o != '0)))
    else $error("denominator inconsistent with status");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .res_den_o (res_den_o),
  .status_o  (status_o)
);
`default_nettype wire
